// ===== rtl/core/btc_pkg.sv =====
// Package for the block transposition cipher.
// Holds payload and control structs, the controller state type and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package btc_pkg;

    // Field widths fixed by the interface
    localparam int CHAR_W       = 8;
    localparam int KEY_W        = 4;
    localparam int PERM_W       = 24;
    localparam int PERM_FIELD_W = 3;
    localparam int CFG_INDEX_W  = 2;

    // Default block length limit
    localparam int MAX_BLOCK_DEF = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] PAD_CHAR   = 8'h78;   // 'x'
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;   // ' '

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_SIZE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PERMUTATION = 2'd1;

    // Register reset values
    localparam logic [KEY_W-1:0]  KEY_SIZE_RST    = 4'd8;
    localparam logic [PERM_W-1:0] PERMUTATION_RST = 24'hFAC688;  // identity

    // Payload structs
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              block_end;
        logic              text_end;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic load_out;   // load next ciphertext byte into output register
    } btc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic trigger;    // the offered input completes or flushes a block
        logic last_byte;  // current emit position is the last of the block
    } btc_sts_t;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } btc_state_t;

endpackage

// ===== rtl/core/btc_ctrl.sv =====
// Controller for the block transposition cipher.
// Sequences input transactions and block emission; owns the output valid flag.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_ctrl
    import btc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  btc_sts_t sts,
    output btc_cmd_t cmd
);

    btc_state_t state_reg;
    btc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // Output register can take a byte when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.trigger)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free && sts.last_byte)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_EMIT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/btc_datapath.sv =====
// Datapath for the block transposition cipher.
// Config registers, block buffer, fill count, emit index and output register.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_datapath
    import btc_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PERM_W-1:0]      cfg_data,
    input  in_item_t               in_data,
    output out_item_t              out_data,
    input  btc_cmd_t               cmd,
    output btc_sts_t               sts
);

    localparam int AW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int FW = $clog2(MAX_BLOCK + 1);
    localparam logic [KEY_W-1:0] MAX_K = KEY_W'(MAX_BLOCK);

    logic [KEY_W-1:0]  key_size_reg;
    logic [PERM_W-1:0] permutation_reg;
    logic [CHAR_W-1:0] buf_mem [MAX_BLOCK];
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     idx_next;
    logic              eot_reg;
    out_item_t         out_reg;

    logic [KEY_W-1:0]        ks;
    logic                    keep;
    logic [KEY_W-1:0]        fill_new_k;
    logic [PERM_FIELD_W-1:0] src;
    logic [CHAR_W-1:0]       byte_sel;

    // Effective block length: 0 acts as 1, clamp at MAX_BLOCK
    always_comb
    begin
        if (key_size_reg == '0)
        begin
            ks = KEY_W'(1);
        end
        else if (key_size_reg > MAX_K)
        begin
            ks = MAX_K;
        end
        else
        begin
            ks = key_size_reg;
        end
    end

    // Fill count after the offered byte
    assign keep       = (in_data.char_in != SPACE_CHAR) && (KEY_W'(fill_reg) < MAX_K);
    assign fill_new_k = KEY_W'(fill_reg) + KEY_W'(keep);
    assign sts.trigger = (fill_new_k >= ks) || (in_data.end_of_text && (fill_new_k != '0));

    // Byte selection for the current emit position; missing bytes read as pad
    assign src           = permutation_reg[PERM_FIELD_W*int'(idx_reg) +: PERM_FIELD_W];
    assign sts.last_byte = (KEY_W'(idx_reg) + KEY_W'(1)) == ks;

    always_comb
    begin
        byte_sel = PAD_CHAR;
        if ((KEY_W'(src) < ks) && (KEY_W'(src) < KEY_W'(fill_reg)))
        begin
            byte_sel = buf_mem[src[AW-1:0]];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg    <= KEY_SIZE_RST;
            permutation_reg <= PERMUTATION_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KEY_SIZE:    key_size_reg    <= cfg_data[KEY_W-1:0];
                REG_PERMUTATION: permutation_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Fill count and emit index
    always_comb
    begin
        fill_next = fill_reg;
        idx_next  = idx_reg;
        if (cmd.accept)
        begin
            fill_next = FW'(fill_new_k);
            idx_next  = '0;
        end
        else if (cmd.load_out)
        begin
            idx_next = idx_reg + AW'(1);
            if (sts.last_byte)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
        end
    end

    // Block buffer and end-of-text flag
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            eot_reg <= in_data.end_of_text;
            if (keep)
            begin
                buf_mem[fill_reg[AW-1:0]] <= in_data.char_in;
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.char_out  <= byte_sel;
            out_reg.block_end <= sts.last_byte;
            out_reg.text_end  <= sts.last_byte && eot_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/core/block_transposition_cipher_top.sv =====
// Top level of the block transposition cipher.
// Instantiates btc_ctrl and btc_datapath; depends on btc_pkg.
//
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+------------------------------
// cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
// in      | in        | in_valid/in_ready    | in_data  (in_item_t)
// out     | out       | out_valid/out_ready  | out_data (out_item_t)
//
// Plaintext bytes are taken while the controller is idle. A byte that
// completes or flushes a block starts a burst of its ciphertext bytes,
// one a cycle from the single output register; no input is taken during
// the burst. Output stalls hold the burst. The configuration channel is
// always ready. Reset restores key_size 8 and the identity permutation;
// the block buffer has no reset.
`timescale 1ns / 1ps

module block_transposition_cipher_top
    import btc_pkg::*;
#(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PERM_W-1:0]      cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data
);

    btc_cmd_t cmd;
    btc_sts_t sts;

    assign cfg_ready = 1'b1;

    btc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    btc_datapath #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== rtl/core/btc_checker.sv =====
// Port-level checker for the block transposition cipher, bound to the top level.
// Depends on btc_pkg.
`timescale 1ns / 1ps

module btc_checker
    import btc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [PERM_W-1:0]      cfg_data,
    input logic                   in_valid,
    input logic                   in_ready,
    input in_item_t               in_data,
    input logic                   out_valid,
    input logic                   out_ready,
    input out_item_t              out_data
);

    // Stalled output transaction keeps valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    // Stalled output transaction keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    // End of text only on the last byte of a block
    a_text_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.text_end |-> out_data.block_end)
        else $error("text_end without block_end");

    // No input taken while a block is still being emitted
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.block_end |-> !in_ready)
        else $error("input ready in the middle of a block");

endmodule

bind block_transposition_cipher_top btc_checker u_btc_checker (.*);
